### design/masked_byte_pattern_scan_top_defines.svh
// ----------------------------------------------------------------------------
// Masked byte pattern scan - assertion macros
// Shared property shapes for the checker of the scanner's ports.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MBPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbps port check failed");

// Next-cycle implication, disabled during reset
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbps port check failed");

`endif

### design/mbps_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scan - package
// Shared constants, register map and the structs passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

   // Defaults of the top level parameters
   localparam int MBPS_MAX_PATTERN = 16;
   localparam int MBPS_OFFSET_BITS = 32;

   // Pattern storage is fixed at 16 bytes
   localparam int PATTERN_BYTES = 16;
   localparam int LEN_W         = 5;

   // Result queue depth, two slots of headroom for a match plus a final
   localparam int RSP_DEPTH = 4;

   // Register map, register i at byte address 8*i
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [2:0] {
      CSR_BASE_ADDRESS = 3'd0,
      CSR_PATTERN_LOW  = 3'd1,
      CSR_PATTERN_HIGH = 3'd2,
      CSR_CARE_MASK    = 3'd3,
      CSR_PATTERN_LEN  = 3'd4,
      CSR_REPORT_ALL   = 3'd5
   } csr_index_type;

   // Live configuration seen by the matcher
   typedef struct packed {
      logic [63:0]                         base_address;
      logic [PATTERN_BYTES-1:0][7:0]       pattern;
      logic [PATTERN_BYTES-1:0]            care_mask;
      logic [LEN_W-1:0]                    pattern_length;
      logic                                report_all;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic [63:0] match_address;
      logic        is_match;
      logic        is_final;
   } result_type;

   // Results made by one byte, first in order first
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

### design/mbps_csr.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scan - register file
// APB-style access to base address, pattern, care mask, length and mode.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_csr
   import mbps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   logic [63:0]              base_ff,  base_in;
   logic [63:0]              pat_lo_ff, pat_lo_in;
   logic [63:0]              pat_hi_ff, pat_hi_in;
   logic [PATTERN_BYTES-1:0] care_ff,  care_in;
   logic [LEN_W-1:0]         len_ff,   len_in;
   logic                     all_ff,   all_in;
   logic                     wr_en;
   csr_index_type            index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign index      = csr_index_type'(csr_paddr[5:3]);

   // Write decode
   always_comb begin
      base_in   = base_ff;
      pat_lo_in = pat_lo_ff;
      pat_hi_in = pat_hi_ff;
      care_in   = care_ff;
      len_in    = len_ff;
      all_in    = all_ff;
      if (wr_en) begin
         case (index)
            CSR_BASE_ADDRESS: base_in   = csr_pwdata;
            CSR_PATTERN_LOW:  pat_lo_in = csr_pwdata;
            CSR_PATTERN_HIGH: pat_hi_in = csr_pwdata;
            CSR_CARE_MASK:    care_in   = csr_pwdata[PATTERN_BYTES-1:0];
            CSR_PATTERN_LEN:  len_in    = csr_pwdata[LEN_W-1:0];
            CSR_REPORT_ALL:   all_in    = csr_pwdata[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         care_ff   <= '0;
         len_ff    <= '0;
         all_ff    <= 1'b0;
      end else begin
         base_ff   <= base_in;
         pat_lo_ff <= pat_lo_in;
         pat_hi_ff <= pat_hi_in;
         care_ff   <= care_in;
         len_ff    <= len_in;
         all_ff    <= all_in;
      end
   end

   // Read mux
   always_comb begin
      case (index)
         CSR_BASE_ADDRESS: csr_prdata = base_ff;
         CSR_PATTERN_LOW:  csr_prdata = pat_lo_ff;
         CSR_PATTERN_HIGH: csr_prdata = pat_hi_ff;
         CSR_CARE_MASK:    csr_prdata = {{(CSR_DATA_W-PATTERN_BYTES){1'b0}}, care_ff};
         CSR_PATTERN_LEN:  csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, len_ff};
         CSR_REPORT_ALL:   csr_prdata = {{(CSR_DATA_W-1){1'b0}}, all_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.base_address   = base_ff;
   assign cfg.pattern        = {pat_hi_ff, pat_lo_ff};
   assign cfg.care_mask      = care_ff;
   assign cfg.pattern_length = len_ff;
   assign cfg.report_all     = all_ff;

endmodule

`default_nettype wire

### design/mbps_matcher.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scan - matcher
// Shift window, parallel masked compare and region bookkeeping, one byte
// per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_matcher
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = MBPS_MAX_PATTERN,
   parameter int OFFSET_BITS = MBPS_OFFSET_BITS
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       end_of_region,
   input  wire cfg_type    cfg,
   output push_type        push
);

   // Only the newest min(MAX_PATTERN, 16) bytes can take part in a match
   localparam int WIN_DEPTH = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
   localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

   logic [WIN_DEPTH-1:0][7:0] win_ff, win_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [OFFSET_BITS-1:0]    seen_ff, seen_in;
   logic [LEN_W-1:0]          skip_ff, skip_in;
   logic                      reported_ff, reported_in;

   logic [LEN_W-1:0]          len;
   logic [PATTERN_BYTES-1:0]  byte_ok;
   logic                      window_hit;
   logic                      fire;
   logic [OFFSET_BITS-1:0]    start;
   result_type                match_res;
   result_type                final_res;

   // Clamp length to the window
   assign len = (cfg.pattern_length > LEN_W'(WIN_DEPTH)) ? LEN_W'(WIN_DEPTH)
                                                         : cfg.pattern_length;

   // Window after this byte, newest at entry 0
   always_comb begin
      win_in[0] = data_byte;
      for (int w = 1; w < WIN_DEPTH; w++) begin
         win_in[w] = win_ff[w-1];
      end
   end

   assign fill_in = (fill_ff < FILL_W'(WIN_DEPTH)) ? fill_ff + 1'b1 : fill_ff;
   assign seen_in = seen_ff + 1'b1;

   // Pattern byte i lines up with window entry len-1-i
   always_comb begin
      for (int i = 0; i < PATTERN_BYTES; i++) begin
         byte_ok[i] = (i >= int'(len)) || !cfg.care_mask[i];
         for (int w = 0; w < WIN_DEPTH; w++) begin
            if ((w + i + 1) == int'(len) && cfg.care_mask[i]) begin
               byte_ok[i] = (win_in[w] == cfg.pattern[i]);
            end
         end
      end
   end

   assign window_hit = &byte_ok;

   assign fire = (skip_ff == '0) && (len != '0)
              && (LEN_W'(fill_in) >= len)
              && (cfg.report_all || !reported_ff) && window_hit;

   assign start = seen_in - OFFSET_BITS'(len);

   assign match_res.match_address = cfg.base_address + 64'(start);
   assign match_res.is_match      = 1'b1;
   assign match_res.is_final      = 1'b0;

   assign final_res.match_address = '0;
   assign final_res.is_match      = 1'b0;
   assign final_res.is_final      = 1'b1;

   // Results for this byte, a match goes ahead of the terminal result
   always_comb begin
      push.count  = '0;
      push.first  = final_res;
      push.second = final_res;
      if (accept) begin
         if (fire) begin
            push.first = match_res;
            push.count = end_of_region ? 2'd2 : 2'd1;
         end else begin
            push.count = end_of_region ? 2'd1 : 2'd0;
         end
      end
   end

   // Skip and first-match bookkeeping
   always_comb begin
      skip_in     = skip_ff;
      reported_in = reported_ff;
      if (skip_ff != '0) begin
         skip_in = skip_ff - 1'b1;
      end else if (fire) begin
         reported_in = 1'b1;
         if (cfg.report_all) begin
            skip_in = len - 1'b1;
         end
      end
   end

   // Window contents need no reset: entries beyond the fill are never compared
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         seen_ff     <= '0;
         skip_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (accept) begin
         if (end_of_region) begin
            fill_ff     <= '0;
            seen_ff     <= '0;
            skip_ff     <= '0;
            reported_ff <= 1'b0;
         end else begin
            fill_ff     <= fill_in;
            seen_ff     <= seen_in;
            skip_ff     <= skip_in;
            reported_ff <= reported_in;
         end
      end
   end

endmodule

`default_nettype wire

### design/mbps_result_fifo.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scan - result queue
// Small queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_result_fifo
   import mbps_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          push_ready,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   output result_type    rsp_head
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   result_type        mem [RSP_DEPTH];
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pop;

   // Ready only while there is room for a match and a terminal result
   assign push_ready = (cnt_ff <= CNT_W'(RSP_DEPTH - 2));
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_head   = mem[rp_ff];
   assign pop        = rsp_tvalid & rsp_tready;

   assign wp_in  = wp_ff + PTR_W'(push.count);
   assign rp_in  = rp_ff + PTR_W'(pop);
   assign cnt_in = cnt_ff + CNT_W'(push.count) - CNT_W'(pop);

   // Storage writes
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wp_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wp_ff + 1'b1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### design/masked_byte_pattern_scan_top.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scan - top level
// Usage:
//   req_ carries one byte of the scanned region per transfer, req_tlast on
//   the region's final byte. rsp_ carries results: rsp_tdata is the match
//   address (base plus start offset), rsp_tuser flags a match and
//   rsp_tlast flags the terminal result that follows the final byte.
//   csr_ is the register port; write it only while the block is idle.
//   Results of a byte are written into the result queue, then shown on rsp_.
//   Throughput: one byte per cycle while req_tready is high; a final byte that
//   also completes a match gives two results, which leave one at a time
//   through the single read port of the result queue.
//   req_tready stays high while the result queue has two free slots, so a
//   stalled receiver backs the input up after a few results.
//   Reset clears region state, queue and CSRs, not the window; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scan_top
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = MBPS_MAX_PATTERN,
   parameter int OFFSET_BITS = MBPS_OFFSET_BITS
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: [7:0] data_byte
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,
   input  wire logic                  req_tlast,
   // rsp_tdata: [63:0] match_address; rsp_tuser: [0] is_match
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [63:0]                rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type    cfg;
   push_type   push;
   result_type head;
   logic       accept;

   assign accept = req_tvalid & req_tready;

   mbps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mbps_matcher #(
      .MAX_PATTERN (MAX_PATTERN),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_matcher (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .end_of_region (req_tlast),
      .cfg           (cfg),
      .push          (push)
   );

   mbps_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_head   (head)
   );

   assign rsp_tdata = head.match_address;
   assign rsp_tuser = head.is_match;
   assign rsp_tlast = head.is_final;

endmodule

`default_nettype wire

### design/mbps_checker.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scan - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_scan_top_defines.svh"

module mbps_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // A stalled result holds
   `MBPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // A result is a match or a terminal result, never both
   `MBPS_ASSERT_NOW(a_kind_excl, clock, reset, rsp_tvalid, !(rsp_tuser && rsp_tlast))

   // Terminal results carry a zero address
   `MBPS_ASSERT_NOW(a_final_zero, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata == 64'd0)

   // A final byte always leaves a result waiting in the next cycle
   `MBPS_ASSERT_NEXT(a_final_out, clock, reset, req_tvalid && req_tready && req_tlast, rsp_tvalid)

endmodule

bind masked_byte_pattern_scan_top mbps_checker u_checker (.*);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked byte pattern scan - testbench
// Streams byte regions into the scanner, writes its registers between phases
// and checks every result against an in-bench model of the window compare.
// A short scripted part covers the reset state, short regions, overlap
// skipping and the clamped length; random phases follow with planted
// patterns, random stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------

module testbench
   import mbps_pkg::*;
();

   localparam int          HALF_PERIOD   = 4;
   localparam int          RESET_CYCLES  = 11;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          STALL_LIMIT   = 2000;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          NUM_PHASES    = 9;
   localparam int          PHASE_BYTES   = 120;
   localparam int          HOLD_PHASE    = 7;
   localparam logic [2:0]  CSR_SPARE_A   = 3'd6;
   localparam logic [2:0]  CSR_SPARE_B   = 3'd7;

   typedef enum logic { ROW_CSR, ROW_BYTE } row_kind_type;
   typedef enum logic [1:0] { BY_MODEL, NO_RESULT, FINAL_ONLY } row_check_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [2:0]    reg_idx;
      logic [63:0]   value;
      logic [7:0]    data;
      logic          last;
      row_check_type check;
   } script_row_type;

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] data_byte
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [63:0]           rsp_tdata;   // [63:0] match_address
   logic                  rsp_tuser;   // [0] is_match
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Scanner model: registers and region state
   logic [63:0]  cfg_base;
   logic [127:0] cfg_pattern;
   logic [15:0]  cfg_care;
   logic [4:0]   cfg_len;
   logic         cfg_all;
   logic [7:0]   win [16];
   int unsigned  win_fill;
   logic [31:0]  region_count;
   logic [4:0]   skip_left;
   bit           found_in_region;

   result_type     pending_results [$];
   script_row_type script [$];

   int  error_count;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  stall_cycles;
   int  hold_left;
   bit  hold_armed;
   bit  hold_done;

   masked_byte_pattern_scan_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Append to the end of the queues
   function automatic void add_row(input script_row_type r);
      script.insert(script.size(), r);
   endfunction

   function automatic void queue_result(input result_type r);
      pending_results.insert(pending_results.size(), r);
   endfunction

   // Region state back to its start values
   task automatic clear_region();
      foreach (win[i]) win[i] = 8'h00;
      win_fill        = 0;
      region_count    = 32'd0;
      skip_left       = 5'd0;
      found_in_region = 1'b0;
   endtask

   // Window compare for one accepted byte; returns up to two results
   task automatic scan_byte(input logic [7:0] b, input logic last, output int n,
                            output result_type r0, output result_type r1);
      int          eff_len;
      logic [31:0] start;
      bit          hit;
      result_type  term;
      eff_len = (cfg_len > 5'd16) ? 16 : int'(cfg_len);
      n  = 0;
      r0 = '0;
      r1 = '0;
      for (int i = 15; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      if (win_fill < 16) win_fill++;
      region_count = region_count + 32'd1;
      hit = 1'b0;
      if (skip_left > 5'd0) begin
         skip_left = skip_left - 5'd1;
      end else if (eff_len > 0 && win_fill >= eff_len && (cfg_all || !found_in_region)) begin
         hit = 1'b1;
         for (int i = 0; i < 16; i++)
            if (i < eff_len && cfg_care[i] && win[eff_len-1-i] != cfg_pattern[8*i +: 8])
               hit = 1'b0;
      end
      if (hit) begin
         start              = region_count - 32'(eff_len);
         r0.match_address   = cfg_base + {32'd0, start};
         r0.is_match        = 1'b1;
         r0.is_final        = 1'b0;
         n                  = 1;
         found_in_region    = 1'b1;
         if (cfg_all) skip_left = 5'(eff_len - 1);
      end
      if (last) begin
         term.match_address = 64'd0;
         term.is_match      = 1'b0;
         term.is_final      = 1'b1;
         if (n == 0) r0 = term;
         else r1 = term;
         n++;
         clear_region();
      end
   endtask

   function automatic script_row_type csr_row(input logic [2:0] idx, input logic [63:0] v);
      script_row_type r;
      r         = '0;
      r.kind    = ROW_CSR;
      r.reg_idx = idx;
      r.value   = v;
      return r;
   endfunction

   function automatic script_row_type byte_row(input logic [7:0] d, input logic l,
                                               input row_check_type chk);
      script_row_type r;
      r       = '0;
      r.kind  = ROW_BYTE;
      r.data  = d;
      r.last  = l;
      r.check = chk;
      return r;
   endfunction

   // One byte transfer; entered and left just after a falling edge
   task automatic send_byte(input logic [7:0] d, input logic l, input row_check_type chk);
      int         n;
      result_type r0;
      result_type r1;
      result_type term;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      scan_byte(d, l, n, r0, r1);
      case (chk)
         BY_MODEL: begin
            if (n >= 1) queue_result(r0);
            if (n == 2) queue_result(r1);
         end
         FINAL_ONLY: begin
            term.match_address = 64'd0;
            term.is_match      = 1'b0;
            term.is_final      = 1'b1;
            queue_result(term);
         end
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Stop offering, wait for all results, then let the pipeline drain
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write: setup then access; model updated at the write edge
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_BASE_ADDRESS: cfg_base             = v;
         CSR_PATTERN_LOW:  cfg_pattern[63:0]    = v;
         CSR_PATTERN_HIGH: cfg_pattern[127:64]  = v;
         CSR_CARE_MASK:    cfg_care             = v[15:0];
         CSR_PATTERN_LEN:  cfg_len              = v[4:0];
         CSR_REPORT_ALL:   cfg_all              = v[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // New register setting for one random phase
   task automatic write_random_config(input int p);
      logic [63:0] v;
      logic [63:0] junk;
      case ($urandom_range(3))
         0:       v = {$urandom, $urandom};
         1:       v = 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(255));
         2:       v = 64'($urandom_range(255));
         default: v = {32'd0, $urandom};
      endcase
      if (p == 1) v = '1;
      if (p == 4) v = '0;
      csr_write(CSR_BASE_ADDRESS, v);
      csr_write(CSR_PATTERN_LOW, {$urandom, $urandom});
      csr_write(CSR_PATTERN_HIGH, {$urandom, $urandom});
      junk = {$urandom, $urandom};
      case ($urandom_range(3))
         0:       v = 64'h0000_FFFF;
         1:       v = 64'h0000_0000;
         default: v = 64'($urandom_range(65535));
      endcase
      if (p == 0) v = 64'h0000_FFFF;
      csr_write(CSR_CARE_MASK, {junk[63:16], v[15:0]});
      case ($urandom_range(9))
         0:       v = 64'd0;
         1:       v = 64'd16;
         2:       v = 64'($urandom_range(31, 17));
         default: v = 64'($urandom_range(6, 1));
      endcase
      if (p == 0) v = 64'd16;
      if (p == 2) v = 64'd1;
      if (p == 5) v = 64'd31;
      junk = {$urandom, $urandom};
      csr_write(CSR_PATTERN_LEN, {junk[63:5], v[4:0]});
      junk = {$urandom, $urandom};
      csr_write(CSR_REPORT_ALL, {junk[63:1], 1'($urandom_range(1))});
      if ($urandom_range(2) == 0)
         csr_write($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, {$urandom, $urandom});
   endtask

   // Random bytes with planted patterns, some of them broken
   task automatic run_random_phase(input int n_bytes);
      int         plant_pos;
      int         eff_len;
      int         idx;
      logic [7:0] d;
      logic       l;
      plant_pos = -1;
      for (int k = 0; k < n_bytes; k++) begin
         eff_len = (cfg_len > 5'd16) ? 16 : int'(cfg_len);
         if (plant_pos < 0 && eff_len > 0 && $urandom_range(5) == 0) plant_pos = 0;
         if (plant_pos >= 0) begin
            if (cfg_care[plant_pos] && $urandom_range(11) != 0)
               d = cfg_pattern[8*plant_pos +: 8];
            else
               d = 8'($urandom);
            plant_pos++;
            if (plant_pos >= eff_len) plant_pos = -1;
         end else if ($urandom_range(1) == 0) begin
            idx = $urandom_range(15);
            d   = cfg_pattern[8*idx +: 8];
         end else begin
            d = 8'($urandom);
         end
         l = ($urandom_range(29) == 0);
         send_byte(d, l, BY_MODEL);
      end
   endtask

   // Receiver readiness, with one long hold-off when armed
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
         if (hold_left == 0) hold_done = 1'b1;
      end else if (hold_armed && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left = HOLD_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: match_address %h is_match %b is_final %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tdata !== exp_r.match_address) begin
               $error("match_address expected %h actual %h", exp_r.match_address, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== exp_r.is_match) begin
               $error("is_match expected %b actual %b", exp_r.is_match, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== exp_r.is_final) begin
               $error("is_final expected %b actual %b", exp_r.is_final, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      script_row_type row;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      error_count   = 0;
      stall_cycles  = 0;
      hold_left     = 0;
      hold_armed    = 1'b0;
      hold_done     = 1'b0;
      send_idle_pct = 38;
      recv_idle_pct = 73;
      cfg_base      = '0;
      cfg_pattern   = '0;
      cfg_care      = '0;
      cfg_len       = '0;
      cfg_all       = 1'b0;
      clear_region();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset state: length zero, only the terminal result
      add_row(byte_row(8'h00, 1'b0, NO_RESULT));
      add_row(byte_row(8'hFF, 1'b1, FINAL_ONLY));
      // Region shorter than the pattern
      add_row(csr_row(CSR_PATTERN_LOW, 64'h0000_0000_0033_2211));
      add_row(csr_row(CSR_CARE_MASK, 64'h0000_0007));
      add_row(csr_row(CSR_PATTERN_LEN, 64'd3));
      add_row(csr_row(CSR_REPORT_ALL, 64'd0));
      add_row(byte_row(8'h11, 1'b0, NO_RESULT));
      add_row(byte_row(8'h22, 1'b1, FINAL_ONLY));
      // All mode, overlapping candidates skipped, address wraps
      add_row(csr_row(CSR_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF));
      add_row(csr_row(CSR_PATTERN_LOW, 64'h0000_0000_0000_AAAA));
      add_row(csr_row(CSR_CARE_MASK, 64'h0000_0003));
      add_row(csr_row(CSR_PATTERN_LEN, 64'd2));
      add_row(csr_row(CSR_REPORT_ALL, 64'd1));
      for (int i = 0; i < 4; i++)
         add_row(byte_row(8'hAA, i == 3, BY_MODEL));
      // Length above 16 clamped, all wildcards: match and terminal together
      add_row(csr_row(CSR_PATTERN_LEN, 64'd31));
      add_row(csr_row(CSR_CARE_MASK, 64'h0000_0000));
      add_row(csr_row(CSR_BASE_ADDRESS, 64'h0123_4567_89AB_CDEF));
      add_row(csr_row(CSR_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF));
      add_row(csr_row(CSR_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF));
      add_row(csr_row(CSR_SPARE_B, 64'h0000_0000_0000_0005));
      for (int i = 0; i < 16; i++)
         add_row(byte_row(8'(8'h80 >> (i % 8)) ^ 8'(i * 37), i == 15, BY_MODEL));

      foreach (script[i]) begin
         row = script[i];
         if (row.kind == ROW_CSR) begin
            settle_block();
            csr_write(row.reg_idx, row.value);
         end else begin
            send_byte(row.data, row.last, row.check);
         end
      end

      // Random phases: three idling profiles, a new setting per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p / 3)
            0:       begin send_idle_pct = 38; recv_idle_pct = 73; end
            1:       begin send_idle_pct = 73; recv_idle_pct = 38; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         settle_block();
         write_random_config(p);
         if (p == HOLD_PHASE) hold_armed = 1'b1;
         run_random_phase(PHASE_BYTES);
      end

      settle_block();
      if (error_count == 0 && pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
